@@ design/srtp_pkg.sv @@
`timescale 1ns / 1ps

package srtp_pkg;

   // Field and register widths.
   localparam int CLK_W   = 30;
   localparam int PRE_W   = 16;
   localparam int BITS_W  = 6;
   localparam int VEL_W   = 32;
   localparam int FUNC_W  = 2;
   localparam int REG_W   = 32;
   localparam int FACT_W  = PRE_W + 1;
   localparam int PROD_W  = VEL_W + FACT_W;
   localparam int RSP_W   = 72;
   localparam int ADDR_W  = 4;

   // Divider sizing: the dividend is the timer clock, one quotient bit per step.
   localparam int DIV_STEPS = CLK_W;
   localparam int CNT_W     = $clog2(DIV_STEPS);

   // Reset values.
   localparam logic [CLK_W-1:0]  RESET_CLOCK  = CLK_W'(72000000);
   localparam int                RESET_RATE   = 1000;
   localparam logic [REG_W-1:0]  RESET_PERIOD = REG_W'(72000000 / RESET_RATE - 1);
   localparam logic [BITS_W-1:0] RESET_BITS   = BITS_W'(16);
   localparam logic [BITS_W-1:0] WIDE_BITS    = BITS_W'(32);

   // Largest quotient whose period still fits a 16-bit counter.
   localparam logic [CLK_W-1:0]  SHORT_MAX_Q  = CLK_W'(65536);

   // Item kinds.
   localparam logic [FUNC_W-1:0] FUNC_SET    = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_CHECK  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_UPDATE = 2'd2;

   // Register indexes.
   localparam logic [1:0] REG_TIMER_CLOCK  = 2'd0;
   localparam logic [1:0] REG_PRESCALER    = 2'd1;
   localparam logic [1:0] REG_COUNTER_BITS = 2'd2;

   typedef struct packed {
      logic load;
      logic mul;
      logic div_init;
      logic div_step;
      logic commit;
   } srtp_cmd_type;

   typedef struct packed {
      logic needs_div;
      logic div_last;
      logic out_free;
   } srtp_status_type;

endpackage

@@ design/srtp_ctrl.sv @@
`timescale 1ns / 1ps

module srtp_ctrl import srtp_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   input  srtp_status_type status,
   output srtp_cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL  = 3'd1;
   localparam logic [2:0] ST_LOAD = 3'd2;
   localparam logic [2:0] ST_DIV  = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = status.needs_div ? ST_MUL : ST_DONE;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            cmd.div_init = 1'b1;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // The result waits here until the output register can take it.
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_div_runs: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && !status.div_last) |=> (state_ff == ST_DIV))
      else $error("divider left before its last step");

   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> status.out_free)
      else $error("commit while the output register is full");

   a_load_path: assert property (@(posedge clock) disable iff (reset)
      (cmd.load && status.needs_div) |=> (state_ff == ST_MUL))
      else $error("rate item skipped the divide path");

endmodule

@@ design/srtp_datapath.sv @@
`timescale 1ns / 1ps

module srtp_datapath import srtp_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  srtp_cmd_type      cmd,
   output srtp_status_type   status,
   input  logic [FUNC_W-1:0] req_func,
   input  logic [VEL_W-1:0]  req_velocity,
   input  logic [CLK_W-1:0]  timer_clock,
   input  logic [PRE_W-1:0]  prescaler,
   input  logic [BITS_W-1:0] counter_bits,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [RSP_W-1:0]  rsp_tdata
);

   logic [FUNC_W-1:0] func_ff;
   logic              neg_ff;
   logic [VEL_W-1:0]  mag_ff;
   logic [VEL_W-1:0]  mag_in;
   logic [PROD_W-1:0] prod_ff;
   logic [FACT_W-1:0] factor;

   logic [CLK_W-1:0]  rem_ff;
   logic [CLK_W-1:0]  quo_ff;
   logic [CLK_W-1:0]  dvsr_ff;
   logic              big_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [CLK_W:0]    trial;
   logic              trial_ge;

   logic [REG_W-1:0]  period_ff;
   logic [REG_W-1:0]  compare_ff;
   logic              pending_ff;
   logic              applied_ff;
   logic [REG_W-1:0]  period_in;
   logic [REG_W-1:0]  compare_in;
   logic              pending_in;
   logic              applied_in;
   logic              accepted_in;

   logic              rsp_tvalid_ff;
   logic [RSP_W-1:0]  rsp_tdata_ff;

   logic              is_rate;
   logic              zero_rate;
   logic              rate_ok;
   logic              q_ok;

   assign mag_in = req_velocity[VEL_W-1] ? (~req_velocity + VEL_W'(1)) : req_velocity;
   assign factor = FACT_W'(prescaler) + FACT_W'(1);

   assign status.needs_div = ((req_func == FUNC_SET) || (req_func == FUNC_CHECK))
                             && (req_velocity != '0);
   assign status.div_last  = (cnt_ff == CNT_W'(DIV_STEPS - 1));
   assign status.out_free  = !rsp_tvalid_ff || rsp_tready;

   // One restoring step: shift in the next dividend bit, subtract when it fits.
   assign trial    = {rem_ff, quo_ff[CLK_W-1]};
   assign trial_ge = (trial >= {1'b0, dvsr_ff});

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff <= req_func;
         neg_ff  <= req_velocity[VEL_W-1];
         mag_ff  <= mag_in;
      end
      if (cmd.mul) begin
         prod_ff <= PROD_W'(mag_ff) * PROD_W'(factor);
      end
      if (cmd.div_init) begin
         rem_ff  <= '0;
         quo_ff  <= timer_clock;
         // A product at or above 2^30 exceeds any clock, so the quotient is zero.
         big_ff  <= |prod_ff[PROD_W-1:CLK_W];
         dvsr_ff <= prod_ff[CLK_W-1:0];
         cnt_ff  <= '0;
      end else if (cmd.div_step) begin
         rem_ff <= trial_ge ? CLK_W'(trial - {1'b0, dvsr_ff}) : trial[CLK_W-1:0];
         quo_ff <= {quo_ff[CLK_W-2:0], trial_ge};
         cnt_ff <= cnt_ff + CNT_W'(1);
      end
   end

   assign is_rate   = (func_ff == FUNC_SET) || (func_ff == FUNC_CHECK);
   assign zero_rate = (mag_ff == '0);
   assign q_ok      = !big_ff && (quo_ff != '0)
                      && ((counter_bits == WIDE_BITS) || (quo_ff <= SHORT_MAX_Q));
   assign rate_ok   = zero_rate || q_ok;

   always_comb begin
      period_in   = period_ff;
      compare_in  = compare_ff;
      pending_in  = pending_ff;
      applied_in  = applied_ff;
      accepted_in = is_rate && rate_ok;
      if (is_rate && rate_ok && (func_ff == FUNC_SET)) begin
         if (zero_rate) begin
            compare_in = '0;
         end else begin
            period_in  = REG_W'(quo_ff) - REG_W'(1);
            compare_in = REG_W'(quo_ff[CLK_W-1:1]);
         end
         pending_in = !zero_rate && !neg_ff;
      end else if (func_ff == FUNC_UPDATE) begin
         applied_in = pending_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff     <= RESET_PERIOD;
         compare_ff    <= '0;
         pending_ff    <= 1'b0;
         applied_ff    <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         if (cmd.commit) begin
            period_ff     <= period_in;
            compare_ff    <= compare_in;
            pending_ff    <= pending_in;
            applied_ff    <= applied_in;
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_tdata_ff <= {5'b0, pending_in, applied_in, compare_in, period_in, accepted_in};
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   a_duty_bound: assert property (@(posedge clock) disable iff (reset)
      compare_ff <= period_ff)
      else $error("compare value above the period");

   a_pin_hold: assert property (@(posedge clock) disable iff (reset)
      !(cmd.commit && func_ff == FUNC_UPDATE) |=> (applied_ff == $past(applied_ff)))
      else $error("direction pin changed without an update event");

   a_commit_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_tvalid_ff)
      else $error("committed result not presented");

endmodule

@@ design/step_rate_to_timer_period.sv @@
`timescale 1ns / 1ps

// Converts signed step-rate commands into a timer period and a half-duty compare value,
// and drives a direction level that follows each timer update event. A set or check of a
// nonzero rate registers the rate times the prescale factor, loads the divider, runs the
// bit-serial restoring divide of the timer clock by that product, then commits and hands
// the result to the output register once it is free. Zero rates, update events and unused
// codes skip the multiply and divide and go straight to the commit. A new beat
// is taken while the previous result still waits in the output register.
module step_rate_to_timer_period import srtp_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   // tdata: velocity [31:0]
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [VEL_W-1:0]  req_tdata,
   // tuser: func [1:0]
   input  logic [FUNC_W-1:0] req_tuser,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   // tdata: accepted [0], period_value [32:1], compare_value [64:33], dir_level [65],
   // dir_pending [66], zero fill [71:67]
   output logic [RSP_W-1:0]  rsp_tdata,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [ADDR_W-1:0] csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   logic [CLK_W-1:0]  timer_clock_ff;
   logic [PRE_W-1:0]  prescaler_ff;
   logic [BITS_W-1:0] counter_bits_ff;
   logic              csr_write;
   logic [1:0]        csr_index;

   srtp_cmd_type      cmd;
   srtp_status_type   status;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         timer_clock_ff  <= RESET_CLOCK;
         prescaler_ff    <= '0;
         counter_bits_ff <= RESET_BITS;
      end else if (csr_write) begin
         case (csr_index)
            REG_TIMER_CLOCK:  timer_clock_ff  <= csr_pwdata[CLK_W-1:0];
            REG_PRESCALER:    prescaler_ff    <= csr_pwdata[PRE_W-1:0];
            REG_COUNTER_BITS: counter_bits_ff <= csr_pwdata[BITS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_TIMER_CLOCK:  csr_prdata = 32'(timer_clock_ff);
         REG_PRESCALER:    csr_prdata = 32'(prescaler_ff);
         REG_COUNTER_BITS: csr_prdata = 32'(counter_bits_ff);
         default:          csr_prdata = '0;
      endcase
   end

   srtp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   srtp_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .req_func     (req_tuser),
      .req_velocity (req_tdata),
      .timer_clock  (timer_clock_ff),
      .prescaler    (prescaler_ff),
      .counter_bits (counter_bits_ff),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata)
   );

endmodule
